### rtl/dlbr_pkg.sv
`default_nettype none
package dlbr_pkg;
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = DATA_WIDTH - 5;
   localparam int ACC_WIDTH  = 40;
   localparam int CMD_DEPTH  = 4;
   localparam int OQ_DEPTH   = 2;

   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_ELEM   = 2'd2;

   localparam logic [1:0] CSR_INNER   = 2'd0;
   localparam logic [1:0] CSR_OUTPUTS = 2'd1;
   localparam logic [1:0] CSR_RELU    = 2'd2;

   typedef struct packed {
      logic [1:0]                   op;
      logic [9:0]                   weight_row;
      logic [4:0]                   weight_col;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [4:0]                   out_column;
      logic signed [DATA_WIDTH-1:0] out_value;
      logic                         last_of_row;
   } rsp_type;

   typedef enum logic [2:0] {
      K_WEIGHT = 3'b001,
      K_BIAS   = 3'b010,
      K_ELEM   = 3'b100
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [9:0]                   row;
      logic [4:0]                   col;
      logic signed [DATA_WIDTH-1:0] value;
   } cmd_type;
endpackage
`default_nettype wire

### rtl/dense_layer_bias_relu.sv
`default_nettype none
// Fully connected layer with bias and optional ReLU, signed Q4.11 in and out,
// 40-bit saturating accumulators. Push items with op 0 (weight at
// weight_row/weight_col), op 1 (bias at weight_col) or op 2 (activation
// element); after inner_length elements one result per output column comes
// out in column order, last_of_row set on the final one. A load item is
// written as the back end takes it. For each element one shared multiplier
// walks the columns, fed by the weight memory's single read port. At the
// end of a row each output column passes a read and a write state for
// bias, rounding and clamping. A 4-item command queue in front and a 2-item
// result queue behind let input and output stall independently.
module dense_layer_bias_relu #(
   parameter int MAX_INNER   = 1024,
   parameter int MAX_OUTPUTS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire dlbr_pkg::req_type req_item,
   output logic                   req_full,
   output dlbr_pkg::rsp_type      rsp_item,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [10:0]       csr_wdata
);
   import dlbr_pkg::*;

   cmd_type cmd_item;
   logic    cmd_empty, cmd_pop;

   dlbr_front #(.MAX_INNER(MAX_INNER), .MAX_OUTPUTS(MAX_OUTPUTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_item),
      .cmd_empty (cmd_empty)
   );

   dlbr_back #(.MAX_INNER(MAX_INNER), .MAX_OUTPUTS(MAX_OUTPUTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_item  (cmd_item),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );
endmodule
`default_nettype wire

### rtl/dlbr_ram.sv
`default_nettype none
module dlbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### rtl/dlbr_front.sv
`default_nettype none
module dlbr_front #(
   parameter int MAX_INNER   = 1024,
   parameter int MAX_OUTPUTS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire dlbr_pkg::req_type req_item,
   output logic                   req_full,
   input  wire logic              cmd_pop,
   output dlbr_pkg::cmd_type      cmd_item,
   output logic                   cmd_empty
);
   import dlbr_pkg::*;

   localparam int PW = $clog2(CMD_DEPTH);

   cmd_type         q_ff [CMD_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            accept, keep, pop;
   cmd_type         cls;

   // classify: unknown ops and out-of-range loads are dropped here
   always_comb begin
      cls.row   = req_item.weight_row;
      cls.col   = req_item.weight_col;
      cls.value = req_item.value;
      cls.kind  = K_ELEM;
      keep      = 1'b0;
      case (req_item.op)
         OP_WEIGHT: begin
            cls.kind = K_WEIGHT;
            keep = (32'(req_item.weight_row) < 32'(MAX_INNER)) &&
                   (32'(req_item.weight_col) < 32'(MAX_OUTPUTS));
         end
         OP_BIAS: begin
            cls.kind = K_BIAS;
            keep = 32'(req_item.weight_col) < 32'(MAX_OUTPUTS);
         end
         OP_ELEM: begin
            cls.kind = K_ELEM;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_full  = (cnt_ff == (PW+1)'(CMD_DEPTH));
   assign cmd_empty = (cnt_ff == '0);
   assign cmd_item  = q_ff[rp_ff];
   assign accept    = req_push && !req_full && keep;
   assign pop       = cmd_pop && !cmd_empty;

   always_comb begin
      wp_in  = accept ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(accept) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (accept) begin
         q_ff[wp_ff] <= cls;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(CMD_DEPTH))
      else $error("command queue overfilled");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop && !accept |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("command queue count lost a pop");
   a_full_no_store: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !accept)
      else $error("stored into a full command queue");
endmodule
`default_nettype wire

### rtl/dlbr_back.sv
`default_nettype none
module dlbr_back #(
   parameter int MAX_INNER   = 1024,
   parameter int MAX_OUTPUTS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dlbr_pkg::cmd_type cmd_item,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [10:0]       csr_wdata,
   output dlbr_pkg::rsp_type      rsp_item,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop
);
   import dlbr_pkg::*;

   localparam int AW   = $clog2(MAX_INNER * MAX_OUTPUTS);
   localparam int CW   = $clog2(MAX_OUTPUTS);
   localparam int IW   = $clog2(MAX_INNER);
   localparam int CNTW = CW + 1;
   localparam int LENW = IW + 1;
   localparam int SW   = ACC_WIDTH + 2;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_MAC     = 4'b0010,
      ST_EMIT_RD = 4'b0100,
      ST_EMIT_WR = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [10:0]                   inner_ff;
   logic [5:0]                    outputs_ff;
   logic                          relu_ff;
   logic [LENW-1:0]               len_eff;
   logic [CNTW-1:0]               cnt_eff;
   logic [IW-1:0]                 ec_ff, ec_in;
   logic [CNTW-1:0]               j_ff, j_in;
   logic signed [DATA_WIDTH-1:0]  val_ff;
   logic                          r1_v_ff, p_v_ff;
   logic [CW-1:0]                 r1_col_ff, p_col_ff;
   logic signed [2*DATA_WIDTH-1:0] prod_ff;
   logic signed [ACC_WIDTH-1:0]   acc_ff [MAX_OUTPUTS];
   logic signed [ACC_WIDTH:0]     acc_sum;
   logic signed [ACC_WIDTH-1:0]   acc_sat;
   logic                          issue, mac_done, row_end;
   logic                          w_we, b_we;
   logic [AW-1:0]                 w_waddr, w_raddr;
   logic [DATA_WIDTH-1:0]         w_rdata, b_rdata;
   logic signed [SW-1:0]          s_sum;
   logic signed [SW-FRAC_BITS-1:0] s_shr;
   logic signed [DATA_WIDTH-1:0]  res_val;
   rsp_type                       res;
   logic                          emit_fire, last_col;
   rsp_type                       oq_ff [OQ_DEPTH];
   logic                          oq_wp_ff, oq_rp_ff;
   logic [1:0]                    oq_cnt_ff;
   logic                          oq_full, oq_pop;

   // register limits
   always_comb begin
      if (inner_ff == '0) len_eff = LENW'(1);
      else if (32'(inner_ff) > 32'(MAX_INNER)) len_eff = LENW'(MAX_INNER);
      else len_eff = LENW'(inner_ff);
      if (outputs_ff == '0) cnt_eff = CNTW'(1);
      else if (32'(outputs_ff) > 32'(MAX_OUTPUTS)) cnt_eff = CNTW'(MAX_OUTPUTS);
      else cnt_eff = CNTW'(outputs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff   <= 11'd784;
         outputs_ff <= 6'd20;
         relu_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INNER:   inner_ff   <= csr_wdata;
            CSR_OUTPUTS: outputs_ff <= csr_wdata[5:0];
            CSR_RELU:    relu_ff    <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;
   assign w_we    = cmd_pop && (cmd_item.kind == K_WEIGHT);
   assign b_we    = cmd_pop && (cmd_item.kind == K_BIAS);
   assign w_waddr = AW'(cmd_item.row) * AW'(MAX_OUTPUTS) + AW'(cmd_item.col);
   assign w_raddr = AW'(ec_ff) * AW'(MAX_OUTPUTS) + AW'(j_ff[CW-1:0]);

   dlbr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_INNER * MAX_OUTPUTS)) u_wram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (cmd_item.value),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   dlbr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_OUTPUTS)) u_bram (
      .clock (clock),
      .we    (b_we),
      .waddr (CW'(cmd_item.col)),
      .wdata (cmd_item.value),
      .raddr (j_ff[CW-1:0]),
      .rdata (b_rdata)
   );

   // MAC pipe: weight read, multiply, saturating accumulate
   assign issue    = (state_ff == ST_MAC) && (j_ff < cnt_eff);
   assign mac_done = (state_ff == ST_MAC) && (j_ff == cnt_eff) && !r1_v_ff && !p_v_ff;
   assign row_end  = (LENW'(ec_ff) + 1'b1) >= len_eff;
   assign acc_sum  = (ACC_WIDTH+1)'(acc_ff[p_col_ff]) + (ACC_WIDTH+1)'(prod_ff);

   always_comb begin
      if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
         acc_sat = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      else
         acc_sat = acc_sum[ACC_WIDTH-1:0];
   end

   // result: round to nearest, ties up, then relu and saturate
   always_comb begin
      s_sum = SW'(acc_ff[j_ff[CW-1:0]])
            + (SW'($signed(b_rdata)) <<< FRAC_BITS)
            + SW'(1 << (FRAC_BITS - 1));
      s_shr = s_sum[SW-1:FRAC_BITS];
      if (relu_ff && s_shr < 0)
         res_val = '0;
      else if (s_shr > (SW-FRAC_BITS)'(2**(DATA_WIDTH-1) - 1))
         res_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else if (s_shr < -(SW-FRAC_BITS)'(2**(DATA_WIDTH-1)))
         res_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else
         res_val = s_shr[DATA_WIDTH-1:0];
      last_col       = (j_ff + 1'b1) == cnt_eff;
      res.out_column = 5'(j_ff[CW-1:0]);
      res.out_value  = res_val;
      res.last_of_row = last_col;
   end

   assign oq_full   = (oq_cnt_ff == 2'(OQ_DEPTH));
   assign emit_fire = (state_ff == ST_EMIT_WR) && !oq_full;

   always_comb begin
      state_in = state_ff;
      ec_in    = ec_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd_item.kind == K_ELEM) begin
               state_in = ST_MAC;
               j_in     = '0;
            end
         end
         ST_MAC: begin
            if (issue) j_in = j_ff + 1'b1;
            if (mac_done) begin
               j_in = '0;
               if (row_end) begin
                  ec_in    = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  ec_in    = ec_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_WR;
         ST_EMIT_WR: begin
            if (emit_fire) begin
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ec_ff    <= '0;
         j_ff     <= '0;
         r1_v_ff  <= 1'b0;
         p_v_ff   <= 1'b0;
         for (int k = 0; k < MAX_OUTPUTS; k++) acc_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         ec_ff    <= ec_in;
         j_ff     <= j_in;
         r1_v_ff  <= issue;
         p_v_ff   <= r1_v_ff;
         if (p_v_ff) acc_ff[p_col_ff] <= acc_sat;
         if (emit_fire && last_col) begin
            for (int k = 0; k < MAX_OUTPUTS; k++) acc_ff[k] <= '0;
         end
      end
      if (cmd_pop && cmd_item.kind == K_ELEM) val_ff <= cmd_item.value;
      r1_col_ff <= j_ff[CW-1:0];
      p_col_ff  <= r1_col_ff;
      prod_ff   <= val_ff * $signed(w_rdata);
   end

   // result queue
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_empty = (oq_cnt_ff == '0);
   assign rsp_item  = oq_ff[oq_rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wp_ff  <= 1'b0;
         oq_rp_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         if (emit_fire) oq_wp_ff <= ~oq_wp_ff;
         if (oq_pop) oq_rp_ff <= ~oq_rp_ff;
         oq_cnt_ff <= oq_cnt_ff + 2'(emit_fire) - 2'(oq_pop);
      end
      if (emit_fire) oq_ff[oq_wp_ff] <= res;
   end

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= 2'(OQ_DEPTH))
      else $error("result queue overfilled");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !cmd_pop)
      else $error("command taken while busy");
   a_pipe_drain: assert property (@(posedge clock) disable iff (reset)
      p_v_ff |-> $past(r1_v_ff))
      else $error("multiply stage without weight read");
   a_emit_state: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> state_ff == ST_IDLE || state_ff == ST_EMIT_RD)
      else $error("bad state after emit");
endmodule
`default_nettype wire
